### rtl/kti_pkg.sv
// Shared constants and types for the key table index search block.
`timescale 1ns / 1ps

package kti_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int GROUP_SIZE    = 32;
    localparam int GROUP_COUNT   = TABLE_ENTRIES / GROUP_SIZE;

    localparam int KEY_W  = 64;
    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int OFF_W  = $clog2(GROUP_SIZE);
    localparam int CFG_W  = 6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } scan_state_t;

    typedef struct packed
    {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed
    {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  data;
    } wr_req_t;

endpackage

### rtl/kti_key_mem.sv
// Key storage: one write port and one registered read port.
`timescale 1ns / 1ps

module kti_key_mem
(
    input  logic                     clk,
    input  kti_pkg::wr_req_t         wr_req,
    input  kti_pkg::rd_req_t         rd_req,
    output logic [kti_pkg::KEY_W-1:0] rd_data
);
    import kti_pkg::*;

    logic [KEY_W-1:0] mem [TABLE_ENTRIES];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en)
        begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/kti_scan.sv
// Query sequencer: walks the table one entry per cycle and reports the result.
`timescale 1ns / 1ps

module kti_scan
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        command,
    input  logic [kti_pkg::KEY_W-1:0]   key_value,
    input  logic                        cfg_valid,
    input  logic [kti_pkg::CFG_W-1:0]   cfg_data,
    output logic                        busy,
    output kti_pkg::rd_req_t            rd_req,
    input  logic [kti_pkg::KEY_W-1:0]   rd_data,
    output logic                        result_valid,
    output logic                        found,
    output logic [kti_pkg::ADDR_W-1:0]  match_index
);
    import kti_pkg::*;

    scan_state_t       state_reg, state_next;
    logic [CFG_W-1:0]  groups_reg, groups_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] hit_idx_reg, hit_idx_next;
    logic              result_valid_reg, result_valid_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] match_index_reg, match_index_next;

    logic [CFG_W-1:0]  groups_sat;
    logic [CNT_W-1:0]  limit_now;
    logic              query_accept;
    logic              match;
    logic              group_end;
    logic              last_entry;
    logic              hit_any;
    logic              finish;
    logic              issue;

    assign busy = (state_reg == ST_SCAN);
    assign query_accept = start && !busy && (command == CMD_QUERY);

    // Group counts beyond the table size saturate to the whole table.
    assign groups_sat = (groups_reg > CFG_W'(GROUP_COUNT)) ? CFG_W'(GROUP_COUNT) : groups_reg;
    assign limit_now  = CNT_W'(groups_sat) << OFF_W;

    assign match      = rd_valid_reg && (rd_data == key_reg);
    assign group_end  = (cmp_idx_reg[OFF_W-1:0] == OFF_W'(GROUP_SIZE - 1));
    assign last_entry = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == limit_reg);
    assign hit_any    = match || hit_reg;
    // The last entry always closes a group, so a hit there is reported too.
    assign finish     = rd_valid_reg && ((group_end && hit_any) || last_entry);
    assign issue      = (state_reg == ST_SCAN) && (issue_reg < limit_reg) && !finish;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_accept && (limit_now != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        groups_next       = groups_reg;
        key_next          = key_reg;
        limit_next        = limit_reg;
        issue_next        = issue_reg;
        rd_valid_next     = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        hit_next          = hit_reg;
        hit_idx_next      = hit_idx_reg;
        result_valid_next = 1'b0;
        found_next        = found_reg;
        match_index_next  = match_index_reg;
        rd_req.en         = 1'b0;
        rd_req.addr       = issue_reg[ADDR_W-1:0];

        if (cfg_valid)
        begin
            groups_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (query_accept)
                begin
                    key_next   = key_value;
                    limit_next = limit_now;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    if (limit_now == '0)
                    begin
                        result_valid_next = 1'b1;
                        found_next        = 1'b0;
                        match_index_next  = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_req.en     = 1'b1;
                    rd_valid_next = 1'b1;
                    cmp_idx_next  = issue_reg[ADDR_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    // Ascending scan: the latest hit in a group is its highest index.
                    if (match)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                    end
                    if (group_end)
                    begin
                        hit_next = 1'b0;
                    end
                end
                if (finish)
                begin
                    result_valid_next = 1'b1;
                    found_next        = hit_any;
                    if (!hit_any)
                    begin
                        match_index_next = '0;
                    end
                    else if (match)
                    begin
                        match_index_next = cmp_idx_reg;
                    end
                    else
                    begin
                        match_index_next = hit_idx_reg;
                    end
                end
            end
            default:
            begin
                rd_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            groups_reg       <= '0;
            rd_valid_reg     <= 1'b0;
            hit_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            groups_reg       <= groups_next;
            rd_valid_reg     <= rd_valid_next;
            hit_reg          <= hit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        limit_reg       <= limit_next;
        issue_reg       <= issue_next;
        cmp_idx_reg     <= cmp_idx_next;
        hit_idx_reg     <= hit_idx_next;
        found_reg       <= found_next;
        match_index_reg <= match_index_next;
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign match_index  = match_index_reg;

    a_scan_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_IDLE) |=> result_valid_reg)
        else $error("scan ended without a result strobe");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !found_reg) |-> (match_index_reg == '0))
        else $error("not-found result carries a nonzero index");

    a_compare_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (CNT_W'(cmp_idx_reg) < limit_reg))
        else $error("compared entry lies outside the groups in use");

    a_read_only_scanning: assert property (@(posedge clk) disable iff (!rst_n)
        rd_req.en |-> (state_reg == ST_SCAN))
        else $error("table read issued outside a scan");

endmodule

### rtl/key_table_index_search.sv
// Top level of the key table index search block.
`timescale 1ns / 1ps

// A write command (command = 0) stores key_value at entry_index and gives no
// result; busy stays low. A query (command = 1) scans the table from entry 0
// upward, one entry per cycle through the single read port of the key memory,
// and stops at the end of the first 32-entry group that holds a match. With g
// groups in use, at most g groups are scanned before the result strobe rises;
// with no groups in use it is high in the cycle right after the transfer.
// busy is high while a query scans. Each result stands on result_valid,
// found and match_index for exactly one cycle and cannot be stalled; a new
// item may be transferred in the same cycle as that strobe. groups_in_use is
// written through cfg_valid/cfg_data; the user must do so only while the
// block is idle, as the block itself does not enforce it; cfg_ready is always high.
// Table entries inside the groups in use must be written before a query reads them.
module key_table_index_search
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic [kti_pkg::ADDR_W-1:0]  entry_index,
    input  logic [kti_pkg::KEY_W-1:0]   key_value,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kti_pkg::CFG_W-1:0]   cfg_data,
    output logic                        result_valid,
    output logic                        found,
    output logic [kti_pkg::ADDR_W-1:0]  match_index
);
    import kti_pkg::*;

    wr_req_t          wr_req;
    rd_req_t          rd_req;
    logic [KEY_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    // Writes are taken only while no scan is running, so they never race a read.
    assign wr_req.en   = start && !busy && (command == CMD_WRITE);
    assign wr_req.addr = entry_index;
    assign wr_req.data = key_value;

    kti_key_mem u_mem
    (
        .clk     (clk),
        .wr_req  (wr_req),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    kti_scan u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .key_value    (key_value),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .busy         (busy),
        .rd_req       (rd_req),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .found        (found),
        .match_index  (match_index)
    );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the key table index search block.
`timescale 1ns / 1ps

module tb_top;

    import kti_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;
    localparam int POOL_SIZE     = 8;
    localparam int PHASES        = 12;

    localparam logic [KEY_W-1:0] KEY_DUP = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_W-1:0] KEY_TOP = 64'h8000_0000_0000_0000;

    typedef struct packed
    {
        logic              cmd;
        logic [ADDR_W-1:0] idx;
        logic [KEY_W-1:0]  key;
    } table_op_t;

    typedef struct packed
    {
        logic              found;
        logic [ADDR_W-1:0] idx;
    } lookup_result_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic              command     = CMD_WRITE;
    logic [ADDR_W-1:0] entry_index = '0;
    logic [KEY_W-1:0]  key_value   = '0;
    logic              cfg_valid   = 1'b0;
    logic [CFG_W-1:0]  cfg_data    = '0;
    logic              busy;
    logic              cfg_ready;
    logic              result_valid;
    logic              found;
    logic [ADDR_W-1:0] match_index;

    // Prediction state: the table mirror is updated on each transfer, groups_cfg on each configuration write.
    logic [KEY_W-1:0]  table_mirror [TABLE_ENTRIES];
    logic [CFG_W-1:0]  groups_cfg = '0;

    // Stimulus-side view of the table, ahead of the block by the queued items.
    logic [KEY_W-1:0]  planned_keys [TABLE_ENTRIES];
    bit                entry_written [TABLE_ENTRIES];
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];

    table_op_t         pending_ops [$];
    lookup_result_t    expected_hits [$];

    bit                gap_free       = 1'b0;
    int                cycle_count    = 0;
    int                mismatch_count = 0;
    int                writes_done    = 0;
    int                lookups_sent   = 0;
    int                hits_seen      = 0;
    int                cfg_writes     = 0;

    int phase_groups [PHASES] = '{3, 1, 5, 0, 2, 8, 4, 6, 1, 7, 2, 3};
    int phase_items  [PHASES] = '{25, 25, 25, 20, 25, 25, 25, 25, 25, 25, 25, 30};

    key_table_index_search uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .entry_index  (entry_index),
        .key_value    (key_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .found        (found),
        .match_index  (match_index)
    );

    always #4 clk = ~clk;

    // Scans the groups in use in ascending order and returns the highest
    // matching entry of the first group that holds the key.
    function automatic lookup_result_t lookup_key(logic [KEY_W-1:0] key);
        lookup_result_t res;
        int             span;
        res  = '0;
        span = (groups_cfg > GROUP_COUNT) ? GROUP_COUNT : int'(groups_cfg);
        for (int grp = 0; grp < span && !res.found; grp++)
        begin
            for (int k = GROUP_SIZE - 1; k >= 0 && !res.found; k--)
            begin
                if (table_mirror[grp * GROUP_SIZE + k] == key)
                begin
                    res.found = 1'b1;
                    res.idx   = ADDR_W'(grp * GROUP_SIZE + k);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(9) < 6)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        if (mismatch_count < REPORT_MAX)
            $display("MISMATCH cycle %0d: %s expected %0h got %0h",
                     cycle_count, what, want, got);
        mismatch_count++;
    endtask

    task automatic queue_write(int idx, logic [KEY_W-1:0] key);
        table_op_t op;
        op.cmd = CMD_WRITE;
        op.idx = ADDR_W'(idx);
        op.key = key;
        pending_ops.push_back(op);
        planned_keys[idx]  = key;
        entry_written[idx] = 1'b1;
    endtask

    task automatic queue_query(logic [KEY_W-1:0] key);
        table_op_t op;
        op.cmd = CMD_QUERY;
        op.idx = ADDR_W'($urandom_range(TABLE_ENTRIES - 1));
        op.key = key;
        pending_ops.push_back(op);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_ops.size() != 0 || expected_hits.size() != 0 || start)
            @(negedge clk);
    endtask

    // The register is only written once every queued item has been taken
    // and every lookup has answered.
    task automatic configure_groups(logic [CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        groups_cfg = value;
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic run_phase(int groups, int n_ops);
        int span;
        int r;
        configure_groups(CFG_W'(groups));
        span = ((groups > GROUP_COUNT) ? GROUP_COUNT : groups) * GROUP_SIZE;
        // Every entry that a lookup may compare against must hold a key first.
        for (int i = 0; i < span; i++)
        begin
            if (!entry_written[i])
                queue_write(i, pick_key());
        end
        repeat (n_ops)
        begin
            r = $urandom_range(99);
            if (r < 30)
            begin
                if (span != 0 && $urandom_range(4) != 0)
                    queue_write($urandom_range(span - 1), pick_key());
                else
                    queue_write($urandom_range(TABLE_ENTRIES - 1), pick_key());
            end
            else if (r < 70 && span != 0)
                queue_query(planned_keys[$urandom_range(span - 1)]);
            else if (r < 85)
                queue_query(key_pool[$urandom_range(POOL_SIZE - 1)]);
            else
                queue_query({$urandom, $urandom});
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_items
        table_op_t op;
        if (!rst_n)
        begin
            start       <= 1'b0;
            command     <= CMD_WRITE;
            entry_index <= '0;
            key_value   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (command == CMD_WRITE)
                begin
                    table_mirror[entry_index] = key_value;
                    writes_done++;
                end
                else
                begin
                    expected_hits.push_back(lookup_key(key_value));
                    lookups_sent++;
                end
            end
            // An item that is not yet taken stays on the ports unchanged.
            if (!start || !busy)
            begin
                if (pending_ops.size() != 0 && (gap_free || $urandom_range(99) >= 31))
                begin
                    op          = pending_ops.pop_front();
                    start       <= 1'b1;
                    command     <= op.cmd;
                    entry_index <= op.idx;
                    key_value   <= op.key;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        lookup_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("result with no lookup outstanding", 64'(0),
                                64'({found, match_index}));
            else
            begin
                want = expected_hits.pop_front();
                if (found !== want.found)
                    report_mismatch("found", 64'(want.found), 64'(found));
                if (match_index !== want.idx)
                    report_mismatch("match_index", 64'(want.idx), 64'(match_index));
                if (found === 1'b1)
                    hits_seen++;
            end
        end
    end

    initial
    begin : stimulus
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = KEY_TOP;
        key_pool[3] = KEY_DUP;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // With no groups in use nothing can match.
        configure_groups('0);
        queue_write(TABLE_ENTRIES - 1, KEY_TOP);
        queue_query('0);
        queue_query('1);

        for (int i = 0; i < GROUP_SIZE; i++)
            queue_write(i, 64'hC0DE_0000_0000_0000 | i);
        queue_write(0, '0);
        queue_write(3, KEY_DUP);
        queue_write(17, KEY_DUP);
        queue_write(31, '1);
        configure_groups(CFG_W'(1));
        queue_query(KEY_DUP);
        queue_query('0);
        queue_query('1);
        queue_query(KEY_TOP);
        queue_query({$urandom, $urandom});

        // A key present in both groups must report the first group only.
        for (int i = GROUP_SIZE; i < 2 * GROUP_SIZE; i++)
            queue_write(i, 64'hBEEF_0000_0000_0000 | i);
        queue_write(40, KEY_DUP);
        queue_write(63, KEY_TOP);
        configure_groups(CFG_W'(2));
        queue_query(KEY_DUP);
        queue_query(KEY_TOP);
        queue_query(64'hBEEF_0000_0000_0021);
        queue_write(17, 64'h5555_5555_5555_5555);
        queue_query(KEY_DUP);
        queue_write(3, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_query(KEY_DUP);

        for (int p = 0; p < PHASES; p++)
        begin
            gap_free = (p == 2);
            run_phase(phase_groups[p], phase_items[p]);
        end
        gap_free = 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);

        $display("Ran %0d table writes and %0d lookups (%0d hits) across %0d group settings.",
                 writes_done, lookups_sent, hits_seen, cfg_writes);
        $display("Group settings went from none up to eight groups, with keys rewritten mid-run.");
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
